[src/ipc_pkg.sv]
package ipc_pkg;

    localparam int MAX_LEN_DEF = 32;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_POW   = 8'h5E;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;

    // precedence levels
    localparam logic [3:0] IP_ADD  = 4'd2;
    localparam logic [3:0] IP_MUL  = 4'd4;
    localparam logic [3:0] IP_POW  = 4'd5;
    localparam logic [3:0] IP_OPND = 4'd7;
    localparam logic [3:0] IP_RPAR = 4'd9;
    localparam logic [3:0] IP_LPAR = 4'd0;
    localparam logic [3:0] SP_ADD  = 4'd1;
    localparam logic [3:0] SP_MUL  = 4'd3;
    localparam logic [3:0] SP_POW  = 4'd6;
    localparam logic [3:0] SP_OPND = 4'd8;
    localparam logic [3:0] SP_OTHER = 4'd0;

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_NEXT,
        S_LATCH,
        S_CMP,
        S_POP,
        S_POPNX,
        S_ERD,
        S_EOUT,
        S_ERR
    } t_state;

    // result of one compare of scanned character against stack top
    typedef struct packed {
        logic bad;  // character not in the table
        logic lt;   // input precedence below stack precedence
        logic eq;   // precedences equal
    } t_cmp;

    function automatic logic is_operand(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]});
    endfunction

    function automatic logic is_operator(input logic [7:0] c);
        return (c == CH_PLUS || c == CH_MINUS || c == CH_MUL || c == CH_DIV || c == CH_POW);
    endfunction

    function automatic logic in_table(input logic [7:0] c);
        return is_operator(c) || is_operand(c) || c == CH_LPAR || c == CH_RPAR;
    endfunction

    function automatic logic [3:0] input_prec(input logic [7:0] c);
        logic [3:0] p;
        p = IP_LPAR;
        if (c == CH_PLUS || c == CH_MINUS)    p = IP_ADD;
        else if (c == CH_MUL || c == CH_DIV)  p = IP_MUL;
        else if (c == CH_POW)                 p = IP_POW;
        else if (is_operand(c))               p = IP_OPND;
        else if (c == CH_RPAR)                p = IP_RPAR;
        return p;
    endfunction

    function automatic logic [3:0] stack_prec(input logic [7:0] c);
        logic [3:0] p;
        p = SP_OTHER;
        if (c == CH_PLUS || c == CH_MINUS)    p = SP_ADD;
        else if (c == CH_MUL || c == CH_DIV)  p = SP_MUL;
        else if (c == CH_POW)                 p = SP_POW;
        else if (is_operand(c))               p = SP_OPND;
        return p;
    endfunction

    // operand +1, operator -1, else 0
    function automatic logic signed [1:0] symbol_rank(input logic [7:0] c);
        logic signed [1:0] r;
        r = 2'sd0;
        if (is_operator(c))     r = -2'sd1;
        else if (is_operand(c)) r = 2'sd1;
        return r;
    endfunction

endpackage

[src/ipc_ram.sv]
module ipc_ram #(
    parameter int DEPTH = ipc_pkg::MAX_LEN_DEF,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/ipc_prec.sv]
module ipc_prec (
    input  logic [7:0]   i_ch,
    input  logic [7:0]   i_top,
    output ipc_pkg::t_cmp o_cmp
);

    logic [3:0] ip;
    logic [3:0] sp;

    always_comb begin
        ip = ipc_pkg::input_prec(i_ch);
        sp = ipc_pkg::stack_prec(i_top);
        o_cmp.bad = !ipc_pkg::in_table(i_ch);
        o_cmp.lt  = (ip < sp);
        o_cmp.eq  = (ip == sp);
    end

endmodule

[src/infix_to_prefix_converter.sv]
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+----------------------------------
// input     | in        | i_in_valid / o_in_ready    | i_symbol[7:0], i_last
// result    | out       | o_out_valid / i_out_ready  | o_symbol_res[7:0], o_last_res,
//           |           |                            | o_invalid
//
// Characters load one per cycle while the block waits for the last one.
// After the last character the sequencer scans the buffer right to left
// through one precedence compare unit: each character is read from the buffer,
// latched and compared; a stack pop adds a stack read and a new compare, and a
// cancelled parenthesis pair adds a stack read (stack memory has a registered
// read); each result is then read from the output store and its request held.
// o_in_ready is low from the last character until the final result is taken.
// Reset is synchronous, active low; no memory clearing is needed.
// A stalled result simply holds; the sequencer waits in place.
module infix_to_prefix_converter #(
    parameter int MAX_LEN = ipc_pkg::MAX_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_symbol,
    input  logic       i_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_symbol_res,
    output logic       o_last_res,
    output logic       o_invalid
);

    localparam int STACK_SIZE = MAX_LEN + 2;
    localparam int CW  = $clog2(MAX_LEN + 1);     // counts 0..MAX_LEN
    localparam int AW  = $clog2(MAX_LEN);         // buffer index
    localparam int SDW = $clog2(STACK_SIZE + 1);  // stack depth 0..STACK_SIZE
    localparam int SAW = $clog2(STACK_SIZE);      // stack index
    localparam int RW  = CW + 1;                  // signed rank

    ipc_pkg::t_state r_state, n_state;

    logic [CW-1:0]        r_icnt, n_icnt;   // buffered characters
    logic                 r_ovf, n_ovf;     // character dropped on full buffer
    logic [CW-1:0]        r_idx, n_idx;     // characters left to scan
    logic                 r_paren, n_paren; // implicit leading '(' already placed
    logic [7:0]           r_ch, n_ch;       // character being placed
    logic [7:0]           r_top, n_top;     // cached top of stack
    logic [SDW-1:0]       r_depth, n_depth;
    logic [CW-1:0]        r_ocnt, n_ocnt;
    logic signed [RW-1:0] r_rank, n_rank;
    logic [AW-1:0]        r_k, n_k;         // output store read pointer

    // memory ports
    logic           in_we, in_re;
    logic [7:0]     in_rdata;
    logic           st_we, st_re;
    logic [7:0]     st_rdata;
    logic           out_we, out_re;
    logic [7:0]     out_rdata;

    logic [CW-1:0]  idx_m1;
    logic [CW-1:0]  ocnt_m1;
    logic [SDW-1:0] depth_m1;
    logic [SDW-1:0] depth_m2;
    logic signed [1:0] top_rank;

    ipc_pkg::t_cmp cmp;

    assign idx_m1   = r_idx - CW'(1);
    assign ocnt_m1  = r_ocnt - CW'(1);
    assign depth_m1 = r_depth - SDW'(1);
    assign depth_m2 = r_depth - SDW'(2);
    assign top_rank = ipc_pkg::symbol_rank(r_top);

    ipc_ram #(.DEPTH(MAX_LEN), .WIDTH(8)) u_infix (
        .i_clk   (i_clk),
        .i_we    (in_we),
        .i_waddr (r_icnt[AW-1:0]),
        .i_wdata (i_symbol),
        .i_re    (in_re),
        .i_raddr (idx_m1[AW-1:0]),
        .o_rdata (in_rdata)
    );

    // stack memory holds every entry but the top, which lives in r_top
    ipc_ram #(.DEPTH(STACK_SIZE), .WIDTH(8)) u_stack (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (depth_m1[SAW-1:0]),
        .i_wdata (r_top),
        .i_re    (st_re),
        .i_raddr (depth_m2[SAW-1:0]),
        .o_rdata (st_rdata)
    );

    ipc_ram #(.DEPTH(MAX_LEN), .WIDTH(8)) u_out (
        .i_clk   (i_clk),
        .i_we    (out_we),
        .i_waddr (r_ocnt[AW-1:0]),
        .i_wdata (r_top),
        .i_re    (out_re),
        .i_raddr (r_k),
        .o_rdata (out_rdata)
    );

    ipc_prec u_prec (
        .i_ch  (r_ch),
        .i_top (r_top),
        .o_cmp (cmp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipc_pkg::S_LOAD;
            r_icnt  <= '0;
            r_ovf   <= 1'b0;
            r_idx   <= '0;
            r_paren <= 1'b0;
            r_depth <= '0;
            r_ocnt  <= '0;
            r_rank  <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_icnt  <= n_icnt;
            r_ovf   <= n_ovf;
            r_idx   <= n_idx;
            r_paren <= n_paren;
            r_depth <= n_depth;
            r_ocnt  <= n_ocnt;
            r_rank  <= n_rank;
            r_k     <= n_k;
        end
        r_ch  <= n_ch;
        r_top <= n_top;
    end

    always_comb begin
        n_state = r_state;
        n_icnt  = r_icnt;
        n_ovf   = r_ovf;
        n_idx   = r_idx;
        n_paren = r_paren;
        n_ch    = r_ch;
        n_top   = r_top;
        n_depth = r_depth;
        n_ocnt  = r_ocnt;
        n_rank  = r_rank;
        n_k     = r_k;
        in_we   = 1'b0;
        in_re   = 1'b0;
        st_we   = 1'b0;
        st_re   = 1'b0;
        out_we  = 1'b0;
        out_re  = 1'b0;

        case (r_state)
            ipc_pkg::S_LOAD: begin
                if (i_in_valid) begin
                    if (r_icnt < CW'(MAX_LEN)) begin
                        in_we  = 1'b1;
                        n_icnt = r_icnt + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last) begin
                        n_state = ipc_pkg::S_INIT;
                    end
                end
            end
            ipc_pkg::S_INIT: begin
                // implicit ')' at the bottom of the stack
                n_depth = SDW'(1);
                n_top   = ipc_pkg::CH_RPAR;
                n_ocnt  = '0;
                n_rank  = '0;
                n_idx   = r_icnt;
                n_paren = 1'b0;
                n_state = r_ovf ? ipc_pkg::S_ERR : ipc_pkg::S_NEXT;
            end
            ipc_pkg::S_NEXT: begin
                if (r_idx != '0) begin
                    in_re   = 1'b1;
                    n_idx   = idx_m1;
                    n_state = ipc_pkg::S_LATCH;
                end else if (!r_paren) begin
                    // implicit '(' in front of the expression
                    n_ch    = ipc_pkg::CH_LPAR;
                    n_paren = 1'b1;
                    n_state = ipc_pkg::S_CMP;
                end else if (r_depth == '0 && r_rank == RW'(1)) begin
                    n_k     = ocnt_m1[AW-1:0];
                    n_state = ipc_pkg::S_ERD;
                end else begin
                    n_state = ipc_pkg::S_ERR;
                end
            end
            ipc_pkg::S_LATCH: begin
                n_ch    = in_rdata;
                n_state = ipc_pkg::S_CMP;
            end
            ipc_pkg::S_CMP: begin
                if (cmp.bad || r_depth == '0) begin
                    n_state = ipc_pkg::S_ERR;
                end else if (cmp.lt) begin
                    // pop top to output store, compare again
                    if (r_ocnt >= CW'(MAX_LEN)) begin
                        n_state = ipc_pkg::S_ERR;
                    end else begin
                        out_we  = 1'b1;
                        n_ocnt  = r_ocnt + CW'(1);
                        n_rank  = r_rank + RW'(top_rank);
                        n_depth = depth_m1;
                        if (r_depth > SDW'(1)) begin
                            st_re   = 1'b1;
                            n_state = ipc_pkg::S_POP;
                        end
                    end
                end else if (!cmp.eq) begin
                    if (r_depth >= SDW'(STACK_SIZE)) begin
                        n_state = ipc_pkg::S_ERR;
                    end else begin
                        st_we   = 1'b1;
                        n_top   = r_ch;
                        n_depth = r_depth + SDW'(1);
                        n_state = ipc_pkg::S_NEXT;
                    end
                end else begin
                    // matching parenthesis: drop it
                    n_depth = depth_m1;
                    if (r_depth > SDW'(1)) begin
                        st_re   = 1'b1;
                        n_state = ipc_pkg::S_POPNX;
                    end else begin
                        n_state = ipc_pkg::S_NEXT;
                    end
                end
            end
            ipc_pkg::S_POP: begin
                n_top   = st_rdata;
                n_state = ipc_pkg::S_CMP;
            end
            ipc_pkg::S_POPNX: begin
                n_top   = st_rdata;
                n_state = ipc_pkg::S_NEXT;
            end
            ipc_pkg::S_ERD: begin
                out_re  = 1'b1;
                n_state = ipc_pkg::S_EOUT;
            end
            ipc_pkg::S_EOUT: begin
                if (i_out_ready) begin
                    if (r_k == '0) begin
                        n_icnt  = '0;
                        n_ovf   = 1'b0;
                        n_state = ipc_pkg::S_LOAD;
                    end else begin
                        n_k     = r_k - AW'(1);
                        n_state = ipc_pkg::S_ERD;
                    end
                end
            end
            ipc_pkg::S_ERR: begin
                if (i_out_ready) begin
                    n_icnt  = '0;
                    n_ovf   = 1'b0;
                    n_state = ipc_pkg::S_LOAD;
                end
            end
            default: begin
                n_state = ipc_pkg::S_LOAD;
            end
        endcase
    end

    assign o_in_ready   = (r_state == ipc_pkg::S_LOAD);
    assign o_out_valid  = (r_state == ipc_pkg::S_EOUT) || (r_state == ipc_pkg::S_ERR);
    assign o_invalid    = (r_state == ipc_pkg::S_ERR);
    assign o_symbol_res = o_invalid ? 8'h00 : out_rdata;
    assign o_last_res   = o_invalid || (r_k == '0);

    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_invalid) |-> (o_last_res && o_symbol_res == 8'h00))
        else $error("error request malformed");

    a_icnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_icnt <= CW'(MAX_LEN))
        else $error("buffer count past capacity");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= SDW'(STACK_SIZE))
        else $error("stack depth past capacity");

    a_done_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_res) |=> (o_in_ready && !o_out_valid))
        else $error("not back to loading after final result");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!o_out_valid && r_ocnt <= CW'(MAX_LEN)))
        else $error("loading while results pending");

endmodule
